// ===== rtl/sem_pkg.sv =====
package sem_pkg;

	localparam int LANES      = 4;
	localparam int MAX_WIDTH  = 2048;
	localparam int CHAN_W     = 8;
	localparam int PIX_W      = LANES * CHAN_W;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = 12;
	localparam int WCFG_W     = 12;
	localparam int NCFG_W     = 3;
	localparam int MAX_HEIGHT = 4095;
	localparam int ENERGY_W   = 15;
	localparam int G_W        = 11;
	localparam int S_W        = 21;
	localparam int FRAC_SH    = 16;
	localparam int SQ_STAGES  = 19;
	localparam int M_W        = SQ_STAGES;
	localparam int RAD_W      = 2 * SQ_STAGES;
	localparam int REM_W      = M_W + 4;
	localparam int SUM_W      = M_W + 2;
	localparam int Q_W        = SUM_W - 4;
	localparam int RECIP3     = 43691;
	localparam int RECIP_W    = 16;
	localparam int RECIP_SH   = 17;
	localparam int LAT        = SQ_STAGES + 4;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [2:0][2:0][CHAN_W-1:0] cwin_t;
	typedef logic [LANES-1:0][M_W-1:0] mag_t;

	typedef struct packed {
		logic             v;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} meta_t;

endpackage

// ===== rtl/sem_if.sv =====
interface sem_pix_if;
	logic  valid;
	logic  ready;
	logic [sem_pkg::CHAN_W-1:0] chan_a;
	logic [sem_pkg::CHAN_W-1:0] chan_b;
	logic [sem_pkg::CHAN_W-1:0] chan_c;
	logic [sem_pkg::CHAN_W-1:0] chan_d;
	modport source (output valid, chan_a, chan_b, chan_c, chan_d, input ready);
	modport sink (input valid, chan_a, chan_b, chan_c, chan_d, output ready);
endinterface

interface sem_nrg_if;
	logic valid;
	logic ready;
	logic [sem_pkg::ENERGY_W-1:0] energy;
	logic [sem_pkg::ROW_W-1:0]    out_row;
	logic [sem_pkg::COL_W-1:0]    out_col;
	logic                         frame_last;
	modport source (output valid, energy, out_row, out_col, frame_last, input ready);
	modport sink (input valid, energy, out_row, out_col, frame_last, output ready);
endinterface

interface sem_cfg_if;
	logic valid;
	logic ready;
	logic [sem_pkg::CFG_IDX_W-1:0]  index;
	logic [sem_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/sem_isqrt.sv =====
module sem_isqrt (
	input  logic                      clk,
	input  logic                      en,
	input  logic [sem_pkg::S_W-1:0]   s,
	output logic [sem_pkg::M_W-1:0]   m
);

	typedef struct packed {
		logic [sem_pkg::REM_W-1:0] rem;
		logic [sem_pkg::M_W-1:0]   root;
		logic [sem_pkg::RAD_W-1:0] rad;
	} sq_t;

	function automatic sq_t sq_step(sq_t a);
		sq_t                       r;
		logic [sem_pkg::REM_W-1:0] cur;
		logic [sem_pkg::REM_W-1:0] t;
		cur = {a.rem[sem_pkg::REM_W-3:0], a.rad[sem_pkg::RAD_W-1 -: 2]};
		t   = {2'b00, a.root, 2'b01};
		r.rad = {a.rad[sem_pkg::RAD_W-3:0], 2'b00};
		if (cur >= t) begin
			r.rem  = cur - t;
			r.root = {a.root[sem_pkg::M_W-2:0], 1'b1};
		end else begin
			r.rem  = cur;
			r.root = {a.root[sem_pkg::M_W-2:0], 1'b0};
		end
		return r;
	endfunction

	sq_t st_in;
	sq_t st_s [1:sem_pkg::SQ_STAGES];

	always_comb begin
		st_in.rem  = '0;
		st_in.root = '0;
		st_in.rad  = {{(sem_pkg::RAD_W - sem_pkg::S_W - sem_pkg::FRAC_SH){1'b0}}, s,
			{sem_pkg::FRAC_SH{1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[1] <= sq_step(st_in);
			for (int i = 2; i <= sem_pkg::SQ_STAGES; i++)
				st_s[i] <= sq_step(st_s[i-1]);
		end
	end

	assign m = st_s[sem_pkg::SQ_STAGES].root;

endmodule

// ===== rtl/sem_lane.sv =====
module sem_lane (
	input  logic                    clk,
	input  logic                    en,
	input  sem_pkg::cwin_t          p,
	output logic [sem_pkg::M_W-1:0] m
);

	logic signed [11:0]           gx_w, gy_w;
	logic signed [sem_pkg::G_W-1:0] gx_s1, gy_s1;
	logic signed [21:0]           sq_w;
	logic [sem_pkg::S_W-1:0]      s_s2;

	always_comb begin
		gx_w = $signed({4'b0, p[0][2]}) + $signed({3'b0, p[1][2], 1'b0}) + $signed({4'b0, p[2][2]})
			- $signed({4'b0, p[0][0]}) - $signed({3'b0, p[1][0], 1'b0}) - $signed({4'b0, p[2][0]});
		gy_w = $signed({4'b0, p[2][0]}) + $signed({3'b0, p[2][1], 1'b0}) + $signed({4'b0, p[2][2]})
			- $signed({4'b0, p[0][0]}) - $signed({3'b0, p[0][1], 1'b0}) - $signed({4'b0, p[0][2]});
		sq_w = gx_s1 * gx_s1 + gy_s1 * gy_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gx_s1 <= gx_w[sem_pkg::G_W-1:0];
			gy_s1 <= gy_w[sem_pkg::G_W-1:0];
			s_s2  <= sq_w[sem_pkg::S_W-1:0];
		end
	end

	sem_isqrt u_isqrt (
		.clk (clk),
		.en  (en),
		.s   (s_s2),
		.m   (m)
	);

endmodule

// ===== rtl/sem_merge.sv =====
module sem_merge (
	input  logic                         clk,
	input  logic                         en,
	input  sem_pkg::mag_t                mag,
	input  logic [sem_pkg::NCFG_W-1:0]   n_eff,
	output logic [sem_pkg::ENERGY_W-1:0] energy
);

	logic [sem_pkg::SUM_W-1:0]              sum_w, sum_s1;
	logic [sem_pkg::Q_W-1:0]                q;
	logic [sem_pkg::Q_W+sem_pkg::RECIP_W-1:0] prod;
	logic [sem_pkg::Q_W-1:0]                e_w;

	always_comb begin
		sum_w = '0;
		for (int k = 0; k < sem_pkg::LANES; k++)
			if (k < int'(n_eff))
				sum_w = sum_w + sem_pkg::SUM_W'(mag[k]);
		q    = sum_s1[sem_pkg::SUM_W-1:4];
		prod = q * sem_pkg::RECIP_W'(sem_pkg::RECIP3);
		case (n_eff)
			3'd1:    e_w = q;
			3'd2:    e_w = q >> 1;
			3'd3:    e_w = sem_pkg::Q_W'(prod >> sem_pkg::RECIP_SH);
			default: e_w = q >> 2;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1 <= sum_w;
			energy <= e_w[sem_pkg::ENERGY_W-1:0];
		end
	end

endmodule

// ===== rtl/sobel_energy_map_core.sv =====
// Throughput: one pixel word per cycle unless the output stalls or the window
// stage still has more than one energy word to issue; a pixel yields two words on
// row ends and the last row, four on the final pixel. Pace is set by the single
// 4-lane Sobel/sqrt pipeline, one energy word per cycle unless the output stalls.
// Reset clears position and valids, sets config 2048x2, 3 chans; not line buffers.
module sobel_energy_map_core (
	input  logic        clk,
	input  logic        arst_n,
	sem_pix_if.sink     pix,
	sem_nrg_if.source   nrg,
	sem_cfg_if.sink     cfg
);

	logic [sem_pkg::WCFG_W-1:0]  w_cfg_q, h_cfg_q, w_eff, h_eff;
	logic [sem_pkg::NCFG_W-1:0]  n_cfg_q, n_eff;
	logic [sem_pkg::COL_W-1:0]   w_last, in_col_q;
	logic [sem_pkg::ROW_W-1:0]   h_last, in_row_q;

	logic                        adv, accept, move, s2_free;
	logic                        col_end, row_end;
	logic [3:0]                  mask_in, mask_q, low;

	logic                        s1_v;
	sem_pkg::pix_t               s1_x, rd_t_s1, rd_p_s1, t_eff;
	logic [sem_pkg::ROW_W-1:0]   s1_r, s2_r;
	logic [sem_pkg::COL_W-1:0]   s1_c, s2_c;
	logic [3:0]                  s1_mask;

	sem_pkg::pix_t               tb_mem [sem_pkg::MAX_WIDTH];
	sem_pkg::pix_t               pr_mem [sem_pkg::MAX_WIDTH];
	logic [2:0][2:0][sem_pkg::PIX_W-1:0] win_q;

	logic                        rep_d, rep_r;
	sem_pkg::meta_t              issue;
	sem_pkg::meta_t              meta_s [1:sem_pkg::LAT];
	sem_pkg::cwin_t              lane_win [sem_pkg::LANES];
	sem_pkg::mag_t               mag;

	always_comb begin
		if (w_cfg_q < sem_pkg::WCFG_W'(2))
			w_eff = sem_pkg::WCFG_W'(2);
		else if (w_cfg_q > sem_pkg::WCFG_W'(sem_pkg::MAX_WIDTH))
			w_eff = sem_pkg::WCFG_W'(sem_pkg::MAX_WIDTH);
		else
			w_eff = w_cfg_q;
		if (h_cfg_q < sem_pkg::WCFG_W'(2))
			h_eff = sem_pkg::WCFG_W'(2);
		else if (h_cfg_q > sem_pkg::WCFG_W'(sem_pkg::MAX_HEIGHT))
			h_eff = sem_pkg::WCFG_W'(sem_pkg::MAX_HEIGHT);
		else
			h_eff = h_cfg_q;
		if (n_cfg_q < sem_pkg::NCFG_W'(1))
			n_eff = sem_pkg::NCFG_W'(1);
		else if (n_cfg_q > sem_pkg::NCFG_W'(sem_pkg::LANES))
			n_eff = sem_pkg::NCFG_W'(sem_pkg::LANES);
		else
			n_eff = n_cfg_q;
	end

	assign w_last = sem_pkg::COL_W'(w_eff - sem_pkg::WCFG_W'(1));
	assign h_last = sem_pkg::ROW_W'(h_eff - sem_pkg::WCFG_W'(1));

	assign adv       = !meta_s[sem_pkg::LAT].v || nrg.ready;
	assign s2_free   = (mask_q & (mask_q - 4'd1)) == 4'd0;
	assign pix.ready = adv && (!s1_v || s2_free);
	assign accept    = pix.valid && pix.ready;
	assign move      = adv && s1_v && s2_free;
	assign cfg.ready = 1'b1;

	assign col_end = (in_col_q == w_last);
	assign row_end = (in_row_q == h_last);
	assign mask_in = {row_end && col_end, row_end && (in_col_q != '0),
		(in_row_q != '0) && col_end, (in_row_q != '0) && (in_col_q != '0)};

	assign t_eff = (s1_r < sem_pkg::ROW_W'(2)) ? rd_p_s1 : rd_t_s1;
	assign low   = mask_q & (~mask_q + 4'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_cfg_q  <= sem_pkg::WCFG_W'(sem_pkg::MAX_WIDTH);
			h_cfg_q  <= sem_pkg::WCFG_W'(2);
			n_cfg_q  <= sem_pkg::NCFG_W'(3);
			in_row_q <= '0;
			in_col_q <= '0;
			s1_v     <= 1'b0;
			mask_q   <= '0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					sem_pkg::REG_IMAGE_WIDTH: begin
						w_cfg_q  <= cfg.data;
						in_row_q <= '0;
						in_col_q <= '0;
					end
					sem_pkg::REG_IMAGE_HEIGHT: begin
						h_cfg_q  <= cfg.data;
						in_row_q <= '0;
						in_col_q <= '0;
					end
					sem_pkg::REG_CHANNEL_COUNT: begin
						n_cfg_q  <= cfg.data[sem_pkg::NCFG_W-1:0];
						in_row_q <= '0;
						in_col_q <= '0;
					end
					default: ;
				endcase
			end else if (accept) begin
				if (col_end) begin
					in_col_q <= '0;
					in_row_q <= row_end ? '0 : in_row_q + sem_pkg::ROW_W'(1);
				end else begin
					in_col_q <= in_col_q + sem_pkg::COL_W'(1);
				end
			end
			if (adv) begin
				if (move)
					mask_q <= s1_mask;
				else
					mask_q <= mask_q & ~low;
				if (!s1_v || s2_free)
					s1_v <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_x    <= {pix.chan_d, pix.chan_c, pix.chan_b, pix.chan_a};
			s1_r    <= in_row_q;
			s1_c    <= in_col_q;
			s1_mask <= mask_in;
			rd_t_s1 <= tb_mem[in_col_q];
			rd_p_s1 <= pr_mem[in_col_q];
		end
		if (move) begin
			tb_mem[s1_c] <= rd_p_s1;
			pr_mem[s1_c] <= s1_x;
			s2_r <= s1_r;
			s2_c <= s1_c;
			for (int i = 0; i < 3; i++)
				win_q[i][0] <= (s1_c == '0) ? ((i == 0) ? t_eff : (i == 1) ? rd_p_s1 : s1_x)
					: win_q[i][1];
			win_q[0][1] <= (s1_c == '0) ? t_eff : win_q[0][2];
			win_q[1][1] <= (s1_c == '0) ? rd_p_s1 : win_q[1][2];
			win_q[2][1] <= (s1_c == '0) ? s1_x : win_q[2][2];
			win_q[0][2] <= t_eff;
			win_q[1][2] <= rd_p_s1;
			win_q[2][2] <= s1_x;
		end
	end

	always_comb begin
		rep_d      = low[2] || low[3];
		rep_r      = low[1] || low[3];
		issue.v    = mask_q != '0;
		issue.last = low[3];
		issue.row  = rep_d ? s2_r : s2_r - sem_pkg::ROW_W'(1);
		issue.col  = rep_r ? s2_c : s2_c - sem_pkg::COL_W'(1);
		for (int k = 0; k < sem_pkg::LANES; k++)
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					lane_win[k][i][j] = win_q[rep_d ? ((i == 0) ? 1 : 2) : i]
						[rep_r ? ((j == 0) ? 1 : 2) : j][sem_pkg::CHAN_W*k +: sem_pkg::CHAN_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= sem_pkg::LAT; i++)
				meta_s[i] <= '0;
		end else if (adv) begin
			meta_s[1] <= issue;
			for (int i = 2; i <= sem_pkg::LAT; i++)
				meta_s[i] <= meta_s[i-1];
		end
	end

	for (genvar k = 0; k < sem_pkg::LANES; k++) begin : g_lane
		sem_lane u_lane (
			.clk (clk),
			.en  (adv),
			.p   (lane_win[k]),
			.m   (mag[k])
		);
	end

	sem_merge u_merge (
		.clk    (clk),
		.en     (adv),
		.mag    (mag),
		.n_eff  (n_eff),
		.energy (nrg.energy)
	);

	assign nrg.valid      = meta_s[sem_pkg::LAT].v;
	assign nrg.out_row    = meta_s[sem_pkg::LAT].row;
	assign nrg.out_col    = meta_s[sem_pkg::LAT].col;
	assign nrg.frame_last = meta_s[sem_pkg::LAT].last;

endmodule

// ===== tb/sobel_energy_map_core_tb.sv =====
`timescale 1ns / 100ps

module sobel_energy_map_core_tb;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 2 * sem_pkg::LAT;
	localparam int PHASE_ITEMS = 129;
	localparam int EDGE_ITEMS = 20;

	typedef struct {
		logic [sem_pkg::ENERGY_W-1:0] energy;
		logic [sem_pkg::ROW_W-1:0]    row;
		logic [sem_pkg::COL_W-1:0]    col;
		logic                         last;
	} energy_word_t;

	typedef struct {
		bit                            is_cfg;
		logic [sem_pkg::CFG_IDX_W-1:0] idx;
		logic [sem_pkg::WCFG_W-1:0]    val;
		sem_pkg::pix_t                 px;
		bit                            typed;
		logic [sem_pkg::ENERGY_W-1:0]  energy;
	} step_t;

	logic clk;
	logic arst_n;

	sem_pix_if pix();
	sem_nrg_if nrg();
	sem_cfg_if cfg();

	sobel_energy_map_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix),
		.nrg(nrg),
		.cfg(cfg)
	);

	// predictor state
	sem_pkg::pix_t line_up1 [sem_pkg::MAX_WIDTH];
	sem_pkg::pix_t line_up2 [sem_pkg::MAX_WIDTH];
	sem_pkg::pix_t win [3][3];
	int unsigned pos_row, pos_col;
	int unsigned reg_width, reg_height, reg_chans;

	energy_word_t pending_energy[$];
	step_t dir_tab[$];

	int errors = 0;
	int send_idle, recv_idle;
	int unsigned cycles = 0;
	logic hold_go;
	logic hold_seen = 1'b0;
	int hold_cnt = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver: random stalls plus one long hold-off on request
	always @(posedge clk) begin
		hold_seen <= hold_go;
		if (hold_go != hold_seen) begin
			hold_cnt <= HOLD_CYCLES;
			nrg.ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			nrg.ready <= 1'b0;
		end else begin
			nrg.ready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	function automatic int unsigned width_eff();
		return (reg_width < 2) ? 2 : (reg_width > sem_pkg::MAX_WIDTH) ? sem_pkg::MAX_WIDTH
			: reg_width;
	endfunction

	function automatic int unsigned height_eff();
		return (reg_height < 2) ? 2 : (reg_height > sem_pkg::MAX_HEIGHT) ? sem_pkg::MAX_HEIGHT
			: reg_height;
	endfunction

	function automatic int unsigned chans_eff();
		return (reg_chans < 1) ? 1 : (reg_chans > sem_pkg::LANES) ? sem_pkg::LANES : reg_chans;
	endfunction

	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned res;
		longint unsigned cand;
		res = 0;
		for (int b = 31; b >= 0; b--) begin
			cand = res | (64'd1 << b);
			if (cand * cand <= v)
				res = cand;
		end
		return res;
	endfunction

	function automatic logic [sem_pkg::ENERGY_W-1:0] sobel_window_energy(input bit rep_down,
			input bit rep_right);
		int sr[3];
		int sc[3];
		int p[3][3];
		int gx, gy;
		int unsigned n;
		longint unsigned acc;
		longint unsigned s;
		n = chans_eff();
		acc = 0;
		for (int i = 0; i < 3; i++) begin
			sr[i] = rep_down ? ((i == 0) ? 1 : 2) : i;
			sc[i] = rep_right ? ((i == 0) ? 1 : 2) : i;
		end
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					p[i][j] = win[sr[i]][sc[j]][8*k +: 8];
			gx = (p[0][2] + 2 * p[1][2] + p[2][2]) - (p[0][0] + 2 * p[1][0] + p[2][0]);
			gy = (p[2][0] + 2 * p[2][1] + p[2][2]) - (p[0][0] + 2 * p[0][1] + p[0][2]);
			s = longint'(gx * gx) + longint'(gy * gy);
			acc += root_floor(s << sem_pkg::FRAC_SH);
		end
		return sem_pkg::ENERGY_W'(acc / (n * 16));
	endfunction

	function automatic void push_energy(input bit rd, input bit rt, input int unsigned row,
			input int unsigned col, input bit last, input bit typed,
			input logic [sem_pkg::ENERGY_W-1:0] tv);
		energy_word_t e;
		e.energy = typed ? tv : sobel_window_energy(rd, rt);
		e.row = sem_pkg::ROW_W'(row);
		e.col = sem_pkg::COL_W'(col);
		e.last = last;
		pending_energy.push_back(e);
	endfunction

	function automatic void advance_pixel(input sem_pkg::pix_t x, input bit typed,
			input logic [sem_pkg::ENERGY_W-1:0] tv);
		int unsigned w, h, r, c;
		sem_pkg::pix_t t, p;
		w = width_eff();
		h = height_eff();
		r = pos_row;
		c = pos_col;
		if (c >= w)
			c = w - 1;
		t = line_up2[c];
		p = line_up1[c];
		if (r < 2)
			t = p;
		for (int i = 0; i < 3; i++) begin
			if (c == 0) begin
				win[i][0] = '0;
				win[i][1] = '0;
			end else begin
				win[i][0] = win[i][1];
				win[i][1] = win[i][2];
			end
		end
		win[0][2] = t;
		win[1][2] = p;
		win[2][2] = x;
		if (c == 0)
			for (int i = 0; i < 3; i++) begin
				win[i][0] = win[i][2];
				win[i][1] = win[i][2];
			end
		line_up2[c] = p;
		line_up1[c] = x;
		if (r >= 1) begin
			if (c >= 1)
				push_energy(0, 0, r - 1, c - 1, 0, typed, tv);
			if (c == w - 1)
				push_energy(0, 1, r - 1, c, 0, typed, tv);
			if (r == h - 1) begin
				if (c >= 1)
					push_energy(1, 0, r, c - 1, 0, typed, tv);
				if (c == w - 1)
					push_energy(1, 1, r, c, 1, typed, tv);
			end
		end
		if (c + 1 >= w) begin
			pos_col = 0;
			pos_row = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			pos_col = c + 1;
			pos_row = r;
		end
	endfunction

	// word checker; inputs change only at posedge, so negedge sampling is race free
	always @(negedge clk) begin
		energy_word_t e;
		if (arst_n && nrg.valid && nrg.ready) begin
			if (pending_energy.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: energy %0d row %0d col %0d last %0b",
						nrg.energy, nrg.out_row, nrg.out_col, nrg.frame_last);
			end else begin
				e = pending_energy.pop_front();
				if (e.energy !== nrg.energy || e.row !== nrg.out_row ||
						e.col !== nrg.out_col || e.last !== nrg.frame_last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp e=%0d r=%0d c=%0d l=%0b got e=%0d r=%0d c=%0d l=%0b",
							e.energy, e.row, e.col, e.last,
							nrg.energy, nrg.out_row, nrg.out_col, nrg.frame_last);
				end
			end
		end
	end

	task automatic drain();
		pix.valid <= 1'b0;
		while (pending_energy.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [sem_pkg::CFG_IDX_W-1:0] idx,
			input logic [sem_pkg::WCFG_W-1:0] val);
		pix.valid <= 1'b0;
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(negedge clk); while (!cfg.ready);
		@(posedge clk);
		cfg.valid <= 1'b0;
		case (idx)
			sem_pkg::REG_IMAGE_WIDTH: reg_width = val;
			sem_pkg::REG_IMAGE_HEIGHT: reg_height = val;
			sem_pkg::REG_CHANNEL_COUNT: reg_chans = val & 3'h7;
			default: ;
		endcase
		pos_row = 0;
		pos_col = 0;
	endtask

	task automatic send_pixel(input sem_pkg::pix_t x, input bit typed,
			input logic [sem_pkg::ENERGY_W-1:0] tv);
		while ($urandom_range(0, 99) < send_idle) begin
			pix.valid <= 1'b0;
			@(posedge clk);
		end
		pix.valid <= 1'b1;
		{pix.chan_d, pix.chan_c, pix.chan_b, pix.chan_a} <= x;
		advance_pixel(x, typed, tv);
		do @(negedge clk); while (!pix.ready);
		@(posedge clk);
	endtask

	function automatic sem_pkg::chan_t rnd_chan();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 1) ? 8'hff : 8'h00;
		return sem_pkg::chan_t'($urandom_range(0, 255));
	endfunction

	function automatic sem_pkg::pix_t rnd_pix();
		return {rnd_chan(), rnd_chan(), rnd_chan(), rnd_chan()};
	endfunction

	function automatic void dcfg(input logic [sem_pkg::CFG_IDX_W-1:0] idx,
			input logic [sem_pkg::WCFG_W-1:0] v);
		step_t s;
		s = '{1'b1, idx, v, '0, 1'b0, '0};
		dir_tab.push_back(s);
	endfunction

	function automatic void dpix(input sem_pkg::pix_t x, input bit typed);
		step_t s;
		s = '{1'b0, sem_pkg::REG_IMAGE_WIDTH, '0, x, typed, '0};
		dir_tab.push_back(s);
	endfunction

	task automatic set_frame(input int w, input int h, input int n);
		drain();
		write_reg(sem_pkg::REG_IMAGE_WIDTH, sem_pkg::WCFG_W'(w));
		write_reg(sem_pkg::REG_IMAGE_HEIGHT, sem_pkg::WCFG_W'(h));
		write_reg(sem_pkg::REG_CHANNEL_COUNT, sem_pkg::WCFG_W'(n));
	endtask

	initial begin
		int sent, frames, count;
		hold_go = 1'b0;
		send_idle = 0;
		recv_idle = 0;
		for (int i = 0; i < sem_pkg::MAX_WIDTH; i++) begin
			line_up1[i] = '0;
			line_up2[i] = '0;
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				win[i][j] = '0;
		pos_row = 0;
		pos_col = 0;
		reg_width = 2048;
		reg_height = 2;
		reg_chans = 3;
		arst_n <= 1'b0;
		pix.valid <= 1'b0;
		{pix.chan_d, pix.chan_c, pix.chan_b, pix.chan_a} <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= sem_pkg::REG_IMAGE_WIDTH;
		cfg.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// flat frames give zero energy; below-range registers saturate to 2x2, one channel
		dcfg(sem_pkg::REG_IMAGE_WIDTH, 12'd0);
		dcfg(sem_pkg::REG_IMAGE_HEIGHT, 12'd1);
		dcfg(sem_pkg::REG_CHANNEL_COUNT, 12'd0);
		repeat (4) dpix(32'h0000_0000, 1'b1);
		dcfg(sem_pkg::REG_CHANNEL_COUNT, 12'd7);
		repeat (4) dpix(32'hffff_ffff, 1'b1);
		dpix(32'hff00_ff00, 1'b0);
		dpix(32'h00ff_00ff, 1'b0);
		dpix(32'h00ff_ff00, 1'b0);
		dpix(32'hff00_00ff, 1'b0);
		dcfg(sem_pkg::REG_IMAGE_WIDTH, 12'd3);
		dcfg(sem_pkg::REG_IMAGE_HEIGHT, 12'd3);
		dcfg(sem_pkg::REG_CHANNEL_COUNT, 12'd3);
		dpix(32'h0000_00ff, 1'b0);
		dpix(32'h00ff_0000, 1'b0);
		dpix(32'hff00_ff00, 1'b0);
		dpix(32'h1234_5678, 1'b0);
		// restart mid-frame
		dcfg(sem_pkg::REG_IMAGE_HEIGHT, 12'd2);
		dpix(32'hffff_ffff, 1'b0);
		dpix(32'h0000_0000, 1'b0);
		dpix(32'hffff_ffff, 1'b0);
		dpix(32'h8040_2010, 1'b0);
		dpix(32'h0102_0408, 1'b0);
		dpix(32'hfedc_ba98, 1'b0);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				drain();
				write_reg(dir_tab[i].idx, dir_tab[i].val);
			end else begin
				send_pixel(dir_tab[i].px, dir_tab[i].typed, dir_tab[i].energy);
			end
		end

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 36 : (ph == 1) ? 66 : 0;
			recv_idle = (ph == 0) ? 66 : (ph == 1) ? 36 : 0;
			sent = 0;
			if (ph == 0) begin
				set_frame(12, 6, 4);
				hold_go = ~hold_go;
				for (int i = 0; i < 72; i++)
					send_pixel(rnd_pix(), 1'b0, '0);
				sent += 72;
			end
			if (ph == 2) begin
				// widest row saturated from above and tallest frame at its limit; a short run into each
				set_frame(4095, 0, 4);
				for (int i = 0; i < EDGE_ITEMS; i++)
					send_pixel(rnd_pix(), 1'b0, '0);
				set_frame(1, sem_pkg::MAX_HEIGHT, 2);
				for (int i = 0; i < EDGE_ITEMS; i++)
					send_pixel(rnd_pix(), 1'b0, '0);
				sent += 2 * EDGE_ITEMS;
			end
			while (sent < PHASE_ITEMS) begin
				set_frame($urandom_range(0, 14), $urandom_range(0, 6), $urandom_range(0, 7));
				frames = $urandom_range(1, 2);
				for (int f = 0; f < frames; f++) begin
					count = width_eff() * height_eff();
					if (f == frames - 1 && $urandom_range(0, 4) == 0)
						count = $urandom_range(1, count);
					if (count > PHASE_ITEMS - sent)
						count = PHASE_ITEMS - sent;
					for (int i = 0; i < count; i++)
						send_pixel(rnd_pix(), 1'b0, '0);
					sent += count;
				end
			end
		end

		drain();
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
